### rtl/core/scsa_pkg.sv
// Shared types, codes and helper functions of the size-class allocator.
package scsa_pkg;

    localparam int NUM_CLASSES = 7;
    localparam int SLOT_W      = 7;
    localparam int PAGE_SHIFT  = 12;
    localparam int MIN_SHIFT   = 5;
    localparam int ADDR_W      = 18;
    localparam int SIZE_W      = 16;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_SIZE = 2'd1;
    localparam logic [1:0] STAT_NO_PAGE  = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef logic [2:0]        class_t;
    typedef logic [SLOT_W-1:0] slot_t;

    typedef struct packed {
        class_t cls;
        slot_t  cnt;
        slot_t  head;
    } page_info_t;

    // usable objects per page: slot 0 is reserved
    function automatic slot_t usable_slots(input class_t c);
        return slot_t'((8'd128 >> c) - 8'd1);
    endfunction

    // smallest class whose object size covers the request; NUM_CLASSES if none
    function automatic class_t class_of(input logic [SIZE_W-1:0] size);
        class_t n;
        n = '0;
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            if ((32'd32 << i) < 32'(size))
            begin
                n = n + 3'd1;
            end
        end
        return n;
    endfunction

endpackage

### rtl/core/size_class_superblock_allocator.sv
// Top level of the size-class allocator: request sequencer and class state.
// The block serves PAGES pages of 4096 bytes split into power-of-two size
// classes of 32 to 2048 bytes, slot 0 of each page reserved. One request is
// handled at a time; s_tready is high only while the sequencer is idle, and
// a finished result sits in the output register so the next request can be
// taken while it waits. The page descriptor memory has separate write and
// read ports with registered read data. Allocate walks the class list,
// reading and checking one page at a time, until a page with a free
// object; when a fresh page is claimed, its n = 4096/size - 1 slots are
// threaded first, one per cycle. Bad sizes and pool-empty answers skip the
// walk. Free of a page still in the pool is answered without a memory read;
// a free that leaves more fully free pages in a class than the reserve
// walks the class list and hands one page back to the pool.
// Nothing to clear after reset: the pool map and class state are flops.
// whole_page_reserve (cfg_wdata, reset 2) sets how many fully free pages a
// class keeps before returning one; write it only while idle.
module size_class_superblock_allocator #(
    parameter int PAGES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // request: tuser = command (0 alloc, 1 free)
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] request_size, [33:16] object_address, [39:34] zero
    input  logic [39:0] s_tdata,
    input  logic        s_tuser,
    // result
    output logic        m_tvalid,
    input  logic        m_tready,
    // [17:0] result_address, [19:18] status, [23:20] zero
    output logic [23:0] m_tdata,
    // whole_page_reserve
    input  logic        cfg_we,
    input  logic [5:0]  cfg_wdata
);

    localparam int PW  = $clog2(PAGES);
    localparam int LW  = PW + 1;
    localparam int FOW = PW + scsa_pkg::SLOT_W;
    localparam int WW  = PW + 1;
    localparam int NC  = scsa_pkg::NUM_CLASSES;
    localparam logic [LW-1:0] NULL_PAGE = '1;
    localparam logic [LW-1:0] PAGES_L   = LW'(PAGES);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ALLOC    = 4'd1;
    localparam logic [3:0] S_THREAD   = 4'd2;
    localparam logic [3:0] S_WALK_RD  = 4'd3;
    localparam logic [3:0] S_WALK_CHK = 4'd4;
    localparam logic [3:0] S_POP      = 4'd5;
    localparam logic [3:0] S_FREE_RD  = 4'd6;
    localparam logic [3:0] S_FREE_CHK = 4'd7;
    localparam logic [3:0] S_REL_RD   = 4'd8;
    localparam logic [3:0] S_REL_CHK  = 4'd9;
    localparam logic [3:0] S_DONE     = 4'd10;

    // control state
    logic [3:0]     state_reg, state_next;
    logic [PAGES-1:0] map_reg, map_next;           // 1 = page in pool
    logic [LW-1:0]  head_reg [NC];
    logic [LW-1:0]  head_next [NC];
    logic [FOW-1:0] fobj_reg [NC];
    logic [FOW-1:0] fobj_next [NC];
    logic [WW-1:0]  whole_reg [NC];
    logic [WW-1:0]  whole_next [NC];
    logic [5:0]     reserve_reg;
    logic           mv_reg, mv_next;

    // working registers
    logic [15:0]             size_reg, size_next;
    logic [17:0]             addr_reg, addr_next;
    scsa_pkg::class_t        cls_reg, cls_next;
    logic [LW-1:0]           page_reg, page_next;
    logic [LW-1:0]           prev_reg, prev_next;
    scsa_pkg::page_info_t    prev_info_reg, prev_info_next;
    logic [LW-1:0]           steps_reg, steps_next;
    logic [LW-1:0]           seen_reg, seen_next;
    scsa_pkg::slot_t         slot_reg, slot_next;
    scsa_pkg::slot_t         thr_reg, thr_next;
    logic [17:0]             pend_addr_reg, pend_addr_next;
    logic [1:0]              pend_stat_reg, pend_stat_next;
    logic [17:0]             out_addr_reg, out_addr_next;
    logic [1:0]              out_stat_reg, out_stat_next;

    // memory ports
    logic                    pm_we, pm_re;
    logic [PW-1:0]           pm_waddr, pm_raddr;
    scsa_pkg::page_info_t    pm_winfo, pm_rinfo;
    logic [LW-1:0]           pm_wlink, pm_rlink;
    logic                    sm_we, sm_re;
    logic [FOW-1:0]          sm_waddr, sm_raddr;
    scsa_pkg::slot_t         sm_wdata, sm_rdata;

    // lowest page in the pool
    logic                    free_found;
    logic [PW-1:0]           free_idx;

    scsa_page_mem #(.PAGES(PAGES)) u_page_mem (
        .clk   (clk),
        .we    (pm_we),
        .waddr (pm_waddr),
        .winfo (pm_winfo),
        .wlink (pm_wlink),
        .re    (pm_re),
        .raddr (pm_raddr),
        .rinfo (pm_rinfo),
        .rlink (pm_rlink)
    );

    scsa_slot_mem #(.PAGES(PAGES)) u_slot_mem (
        .clk   (clk),
        .we    (sm_we),
        .waddr (sm_waddr),
        .wdata (sm_wdata),
        .re    (sm_re),
        .raddr (sm_raddr),
        .rdata (sm_rdata)
    );

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = PAGES - 1; i >= 0; i--)
        begin
            if (map_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = PW'(i);
            end
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = {4'b0, out_stat_reg, out_addr_reg};

    // sequencer
    always_comb
    begin
        scsa_pkg::class_t c;
        scsa_pkg::slot_t  s;
        scsa_pkg::slot_t  full;
        logic [PW-1:0]    fp;
        logic [WW-1:0]    nw;
        logic [LW-1:0]    seen_inc;

        state_next     = state_reg;
        map_next       = map_reg;
        head_next      = head_reg;
        fobj_next      = fobj_reg;
        whole_next     = whole_reg;
        mv_next        = mv_reg;
        size_next      = size_reg;
        addr_next      = addr_reg;
        cls_next       = cls_reg;
        page_next      = page_reg;
        prev_next      = prev_reg;
        prev_info_next = prev_info_reg;
        steps_next     = steps_reg;
        seen_next      = seen_reg;
        slot_next      = slot_reg;
        thr_next       = thr_reg;
        pend_addr_next = pend_addr_reg;
        pend_stat_next = pend_stat_reg;
        out_addr_next  = out_addr_reg;
        out_stat_next  = out_stat_reg;

        pm_we    = 1'b0;
        pm_re    = 1'b0;
        pm_waddr = page_reg[PW-1:0];
        pm_raddr = page_reg[PW-1:0];
        pm_winfo = pm_rinfo;
        pm_wlink = pm_rlink;
        sm_we    = 1'b0;
        sm_re    = 1'b0;
        sm_waddr = {page_reg[PW-1:0], thr_reg};
        sm_raddr = {page_reg[PW-1:0], pm_rinfo.head};
        sm_wdata = pm_rinfo.head;

        c        = scsa_pkg::class_of(size_reg);
        s        = '0;
        full     = scsa_pkg::usable_slots(cls_reg);
        fp       = PW'(addr_reg[17:12]);
        nw       = '0;
        seen_inc = seen_reg + 1'b1;

        if (mv_reg && m_tready)
        begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    size_next  = s_tdata[15:0];
                    addr_next  = s_tdata[33:16];
                    state_next = (s_tuser == scsa_pkg::CMD_FREE) ? S_FREE_RD : S_ALLOC;
                end
            end

            S_ALLOC:
            begin
                cls_next       = c;
                pend_addr_next = '0;
                if (size_reg == '0 || 32'(c) >= NC)
                begin
                    pend_stat_next = scsa_pkg::STAT_BAD_SIZE;
                    state_next     = S_DONE;
                end
                else if (fobj_reg[c] == '0)
                begin
                    if (!free_found)
                    begin
                        pend_stat_next = scsa_pkg::STAT_NO_PAGE;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        // claim the page; stack head ends at the top slot
                        full          = scsa_pkg::usable_slots(c);
                        map_next[free_idx] = 1'b0;
                        pm_we         = 1'b1;
                        pm_waddr      = free_idx;
                        pm_winfo      = '{cls: c, cnt: full, head: full};
                        pm_wlink      = head_reg[c];
                        head_next[c]  = LW'(free_idx);
                        whole_next[c] = whole_reg[c] + 1'b1;
                        fobj_next[c]  = fobj_reg[c] + FOW'(full);
                        page_next     = LW'(free_idx);
                        thr_next      = scsa_pkg::slot_t'(1);
                        state_next    = S_THREAD;
                    end
                end
                else
                begin
                    page_next  = head_reg[c];
                    steps_next = '0;
                    state_next = S_WALK_RD;
                end
            end

            S_THREAD:
            begin
                // slot s links to s-1; slot 1 ends the stack
                sm_we    = 1'b1;
                sm_waddr = {page_reg[PW-1:0], thr_reg};
                sm_wdata = thr_reg - 1'b1;
                if (thr_reg == full)
                begin
                    steps_next = '0;
                    state_next = S_WALK_RD;
                end
                else
                begin
                    thr_next = thr_reg + 1'b1;
                end
            end

            S_WALK_RD:
            begin
                if (steps_reg >= PAGES_L || page_reg >= PAGES_L)
                begin
                    pend_stat_next = scsa_pkg::STAT_NO_PAGE;
                    state_next     = S_DONE;
                end
                else
                begin
                    pm_re      = 1'b1;
                    state_next = S_WALK_CHK;
                end
            end

            S_WALK_CHK:
            begin
                if (pm_rinfo.cnt != '0)
                begin
                    slot_next  = pm_rinfo.head;
                    sm_re      = 1'b1;
                    state_next = S_POP;
                end
                else
                begin
                    page_next  = pm_rlink;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_WALK_RD;
                end
            end

            S_POP:
            begin
                pm_we    = 1'b1;
                pm_winfo = '{cls: pm_rinfo.cls, cnt: pm_rinfo.cnt - 1'b1, head: sm_rdata};
                pm_wlink = pm_rlink;
                if (fobj_reg[cls_reg] != '0)
                begin
                    fobj_next[cls_reg] = fobj_reg[cls_reg] - 1'b1;
                end
                if (pm_rinfo.cnt == full && whole_reg[cls_reg] != '0)
                begin
                    whole_next[cls_reg] = whole_reg[cls_reg] - 1'b1;
                end
                pend_addr_next = 18'((32'(page_reg) << scsa_pkg::PAGE_SHIFT)
                                     + (32'(slot_reg) << (scsa_pkg::MIN_SHIFT + 32'(cls_reg))));
                pend_stat_next = scsa_pkg::STAT_OK;
                state_next     = S_DONE;
            end

            S_FREE_RD:
            begin
                pend_addr_next = '0;
                pend_stat_next = scsa_pkg::STAT_OK;
                if (32'(addr_reg[17:12]) >= PAGES || map_reg[fp])
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    pm_re      = 1'b1;
                    pm_raddr   = fp;
                    page_next  = LW'(fp);
                    state_next = S_FREE_CHK;
                end
            end

            S_FREE_CHK:
            begin
                state_next = S_DONE;
                c          = pm_rinfo.cls;
                if (32'(c) < NC)
                begin
                    full = scsa_pkg::usable_slots(c);
                    s    = scsa_pkg::slot_t'(addr_reg[11:0] >> (scsa_pkg::MIN_SHIFT + 32'(c)));
                    if (s != '0 && pm_rinfo.cnt < full)
                    begin
                        sm_we         = 1'b1;
                        sm_waddr      = {page_reg[PW-1:0], s};
                        sm_wdata      = pm_rinfo.head;
                        pm_we         = 1'b1;
                        pm_winfo      = '{cls: c, cnt: pm_rinfo.cnt + 1'b1, head: s};
                        pm_wlink      = pm_rlink;
                        fobj_next[c]  = fobj_reg[c] + 1'b1;
                        nw            = whole_reg[c]
                                        + WW'(pm_rinfo.cnt + 1'b1 == full);
                        whole_next[c] = nw;
                        cls_next      = c;
                        if (32'(nw) > 32'(reserve_reg))
                        begin
                            page_next  = head_reg[c];
                            prev_next  = NULL_PAGE;
                            seen_next  = '0;
                            steps_next = '0;
                            state_next = S_REL_RD;
                        end
                    end
                end
            end

            S_REL_RD:
            begin
                if (steps_reg >= PAGES_L || page_reg >= PAGES_L)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    pm_re      = 1'b1;
                    state_next = S_REL_CHK;
                end
            end

            S_REL_CHK:
            begin
                state_next = S_REL_RD;
                prev_next      = page_reg;
                prev_info_next = pm_rinfo;
                page_next      = pm_rlink;
                steps_next     = steps_reg + 1'b1;
                if (pm_rinfo.cnt == full)
                begin
                    seen_next = seen_inc;
                    if (32'(seen_inc) > 32'(reserve_reg))
                    begin
                        // unlink and hand the page back to the pool
                        if (prev_reg == NULL_PAGE)
                        begin
                            head_next[cls_reg] = pm_rlink;
                        end
                        else
                        begin
                            pm_we    = 1'b1;
                            pm_waddr = prev_reg[PW-1:0];
                            pm_winfo = prev_info_reg;
                            pm_wlink = pm_rlink;
                        end
                        map_next[page_reg[PW-1:0]] = 1'b1;
                        whole_next[cls_reg] = whole_reg[cls_reg] - 1'b1;
                        fobj_next[cls_reg]  = (fobj_reg[cls_reg] >= FOW'(full))
                                              ? fobj_reg[cls_reg] - FOW'(full) : '0;
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (!mv_reg || m_tready)
                begin
                    out_addr_next = pend_addr_reg;
                    out_stat_next = pend_stat_reg;
                    mv_next       = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            map_reg     <= '1;
            mv_reg      <= 1'b0;
            reserve_reg <= 6'd2;
            for (int i = 0; i < NC; i++)
            begin
                head_reg[i]  <= NULL_PAGE;
                fobj_reg[i]  <= '0;
                whole_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            map_reg   <= map_next;
            mv_reg    <= mv_next;
            head_reg  <= head_next;
            fobj_reg  <= fobj_next;
            whole_reg <= whole_next;
            if (cfg_we)
            begin
                reserve_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg      <= size_next;
        addr_reg      <= addr_next;
        cls_reg       <= cls_next;
        page_reg      <= page_next;
        prev_reg      <= prev_next;
        prev_info_reg <= prev_info_next;
        steps_reg     <= steps_next;
        seen_reg      <= seen_next;
        slot_reg      <= slot_next;
        thr_reg       <= thr_next;
        pend_addr_reg <= pend_addr_next;
        pend_stat_reg <= pend_stat_next;
        out_addr_reg  <= out_addr_next;
        out_stat_reg  <= out_stat_next;
    end

`ifndef SYNTHESIS
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in flight");

    a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        !(pm_we && pm_re && pm_waddr == pm_raddr))
        else $error("page memory read and write hit one entry");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK_CHK || state_reg == S_REL_CHK) |-> steps_reg < PAGES_L)
        else $error("list walk ran past page count");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        mv_reg |-> (out_stat_reg == scsa_pkg::STAT_OK
                    || out_stat_reg == scsa_pkg::STAT_BAD_SIZE
                    || out_stat_reg == scsa_pkg::STAT_NO_PAGE))
        else $error("undefined status code");
`endif

endmodule

### rtl/core/scsa_page_mem.sv
// Per-page descriptor memory: class, free count, stack head and list link.
module scsa_page_mem #(
    parameter int PAGES = 64,
    localparam int PW = $clog2(PAGES),
    localparam int LW = PW + 1
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [PW-1:0]            waddr,
    input  scsa_pkg::page_info_t     winfo,
    input  logic [LW-1:0]            wlink,
    input  logic                     re,
    input  logic [PW-1:0]            raddr,
    output scsa_pkg::page_info_t     rinfo,
    output logic [LW-1:0]            rlink
);

    scsa_pkg::page_info_t info_mem [PAGES];
    logic [LW-1:0]        link_mem [PAGES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            info_mem[waddr] <= winfo;
            link_mem[waddr] <= wlink;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rinfo <= info_mem[raddr];
            rlink <= link_mem[raddr];
        end
    end

endmodule

### rtl/core/scsa_slot_mem.sv
// Object link memory: next-free slot for every slot of every page.
module scsa_slot_mem #(
    parameter int PAGES = 64,
    localparam int AW = $clog2(PAGES) + scsa_pkg::SLOT_W
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  scsa_pkg::slot_t      wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output scsa_pkg::slot_t      rdata
);

    scsa_pkg::slot_t link_mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            link_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= link_mem[raddr];
        end
    end

endmodule
